// ===== hw/rtl/dcs_pkg.sv =====
// ---------------------------------------------------------------------------
// dcs_pkg
// Types and constants shared by the copy sequencer modules.
// ---------------------------------------------------------------------------
package dcs_pkg;

   localparam int unsigned ADDR_WIDTH_DEF = 64;
   localparam logic [31:0] TIMEOUT_RESET  = 32'd5000;

   localparam logic [1:0] REQ_SUBMIT    = 2'd0;
   localparam logic [1:0] REQ_POLL      = 2'd1;
   localparam logic [1:0] REQ_TICK_POLL = 2'd2;

   localparam logic [1:0] DOM_HOST   = 2'd0;
   localparam logic [1:0] DOM_DEVICE = 2'd1;

   localparam logic [2:0] ACT_NONE     = 3'd0;
   localparam logic [2:0] ACT_PUBLISH  = 3'd1;
   localparam logic [2:0] ACT_CACHE    = 3'd2;
   localparam logic [2:0] ACT_HOST_DMA = 3'd3;
   localparam logic [2:0] ACT_DEV_DMA  = 3'd4;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_BUSY      = 4'd1;
   localparam logic [3:0] ST_NOT_READY = 4'd2;
   localparam logic [3:0] ST_BAD_PAIR  = 4'd3;
   localparam logic [3:0] ST_BAD_ADDR  = 4'd4;
   localparam logic [3:0] ST_BAD_RANGE = 4'd5;
   localparam logic [3:0] ST_OVERLAP   = 4'd6;
   localparam logic [3:0] ST_TIMEOUT   = 4'd7;
   localparam logic [3:0] ST_BUS_ERROR = 4'd8;

   localparam logic [2:0] DMA_IDLE    = 3'd0;
   localparam logic [2:0] DMA_DONE    = 3'd2;
   localparam logic [2:0] DMA_BUS_ERR = 3'd3;
   localparam logic [2:0] DMA_BAD_DSC = 3'd4;

   localparam logic [2:0] CSR_GMEM_BASE = 3'd0;
   localparam logic [2:0] CSR_GMEM_SIZE = 3'd1;
   localparam logic [2:0] CSR_NC_BASE   = 3'd2;
   localparam logic [2:0] CSR_NC_SIZE   = 3'd3;
   localparam logic [2:0] CSR_HEAP_BASE = 3'd4;
   localparam logic [2:0] CSR_HEAP_SIZE = 3'd5;
   localparam logic [2:0] CSR_TIMEOUT   = 3'd6;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] from_addr;
      logic [63:0] to_addr;
      logic [63:0] length;
      logic [1:0]  from_space;
      logic [1:0]  to_space;
      logic [63:0] token;
      logic        ready_ok;
      logic        predecessor_busy;
      logic        cache_pending;
      logic [2:0]  host_dma_status;
      logic [2:0]  device_dma_status;
   } req_type_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [63:0]       done_token;
      logic [3:0]        done_status;
      logic [63:0]       cmd_addr0;
      logic [63:0]       cmd_addr1;
      logic signed [63:0] cmd_length;
      logic              cache_mode;
      logic              timeout_fault;
      logic              busy_res;
   } rsp_type_type;

   typedef struct packed {
      logic [63:0] base;
      logic [63:0] size;
   } window_type;

endpackage

// ===== hw/rtl/dma_copy_sequencer.sv =====
// ---------------------------------------------------------------------------
// dma_copy_sequencer
// Single-copy DMA sequencer: submit checks and per-poll phase stepping.
// ---------------------------------------------------------------------------
// Each transaction (submit or poll) is evaluated combinationally from the
// registered sequencer state and produces exactly one response, held in an
// output register with a skid stage, so one transaction per cycle is
// sustained while the response side keeps up. The response is registered,
// passing through the skid stage while the output register is stalled.
module dma_copy_sequencer #(
   parameter int unsigned ADDR_WIDTH = dcs_pkg::ADDR_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dcs_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dcs_pkg::rsp_type_type rsp_data,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [63:0]           csr_wdata
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_WAIT_PRED, PH_FLUSH_SRC, PH_FLUSH_DST, PH_WAIT_DMA, PH_INV_DST,
      PH_DRAIN
   } phase_type;

   localparam logic [63:0] AMASK = (~64'd0) >> (64 - ADDR_WIDTH);
   localparam logic [63:0] I64MAX = {1'b0, {63{1'b1}}};

   dcs_pkg::window_type [2:0] win_ff;
   logic [31:0] tmo_ff;

   phase_type   phase_ff, phase_in;
   logic [ADDR_WIDTH-1:0] src_ff, src_in, dst_ff, dst_in;
   logic [63:0] len_ff, len_in, tok_ff, tok_in;
   logic        sdev_ff, sdev_in, ddev_ff, ddev_in;
   logic [31:0] ticks_ff, ticks_in;

   dcs_pkg::rsp_type_type r, out_ff, skid_ff;
   logic out_v_ff, skid_v_ff;

   logic acc;
   assign req_ready = !skid_v_ff;
   assign acc = req_valid && req_ready;
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

   logic [63:0] sa, da, n, csrc, cdst;
   logic sok, dok;
   assign sa = req_data.from_addr & AMASK;
   assign da = req_data.to_addr & AMASK;
   assign n  = req_data.length;
   assign csrc = 64'(src_ff);
   assign cdst = 64'(dst_ff);

   dcs_window_check u_src_chk (.addr(sa), .len(n), .win(win_ff), .inside_ok(sok));
   dcs_window_check u_dst_chk (.addr(da), .len(n), .win(win_ff), .inside_ok(dok));

   always_comb begin
      logic sd, dd, pair_ok, host_ok, dev_ok, ovl, pend, timed;
      logic [31:0] tk;
      logic [2:0] s, hs, ds;
      r = '0;
      phase_in = phase_ff;
      src_in = src_ff; dst_in = dst_ff; len_in = len_ff; tok_in = tok_ff;
      sdev_in = sdev_ff; ddev_in = ddev_ff; ticks_in = ticks_ff;
      sd = req_data.from_space == dcs_pkg::DOM_DEVICE;
      dd = req_data.to_space == dcs_pkg::DOM_DEVICE;
      pair_ok = (req_data.from_space == dcs_pkg::DOM_HOST && dd) || sd;
      pair_ok = pair_ok && !(sd && req_data.to_space[1]);
      host_ok = (n == 64'd0) ||
                ((req_data.from_space == dcs_pkg::DOM_HOST ? sa : da) != 64'd0);
      dev_ok = (n == 64'd0) || ((!sd || sok) && (!dd || dok));
      if (n == 64'd0) ovl = 1'b0;
      else if (sa > ~n || da > ~n) ovl = 1'b1;
      else ovl = !(((sa + n) <= da) || ((da + n) <= sa));
      pend = req_data.cache_pending;
      hs = req_data.host_dma_status;
      ds = req_data.device_dma_status;
      s = (sdev_ff && ddev_ff) ? ds : hs;
      tk = ticks_ff;
      if (req_data.req_type == dcs_pkg::REQ_TICK_POLL && tk != '1) tk = tk + 32'd1;
      timed = phase_ff != PH_WAIT_PRED && phase_ff != PH_DRAIN && tk >= tmo_ff;
      unique case (req_data.req_type)
         dcs_pkg::REQ_SUBMIT: begin
            r.action = dcs_pkg::ACT_PUBLISH;
            r.done_token = req_data.token;
            priority if (phase_ff != PH_IDLE) r.done_status = dcs_pkg::ST_BUSY;
            else if (!req_data.ready_ok) r.done_status = dcs_pkg::ST_NOT_READY;
            else if (!pair_ok) r.done_status = dcs_pkg::ST_BAD_PAIR;
            else if (!host_ok) r.done_status = dcs_pkg::ST_BAD_ADDR;
            else if (!dev_ok || n > I64MAX) r.done_status = dcs_pkg::ST_BAD_RANGE;
            else if (sd && dd && ovl) r.done_status = dcs_pkg::ST_OVERLAP;
            else begin
               r = '0;
               src_in = sa[ADDR_WIDTH-1:0]; dst_in = da[ADDR_WIDTH-1:0];
               len_in = n; sdev_in = sd; ddev_in = dd; tok_in = req_data.token;
               phase_in = PH_WAIT_PRED; ticks_in = '0;
            end
         end
         dcs_pkg::REQ_POLL, dcs_pkg::REQ_TICK_POLL: begin
            ticks_in = tk;
            if (phase_ff == PH_IDLE) begin
               phase_in = PH_IDLE;
            end else if (timed) begin
               r.timeout_fault = 1'b1;
               r.action = dcs_pkg::ACT_PUBLISH;
               r.done_token = tok_ff;
               r.done_status = dcs_pkg::ST_TIMEOUT;
               phase_in = (phase_ff == PH_WAIT_DMA) ? PH_DRAIN : PH_IDLE;
            end else begin
               unique case (phase_ff)
                  PH_WAIT_PRED, PH_FLUSH_SRC, PH_FLUSH_DST: begin
                     logic go, fsrc, fdst;
                     go = (phase_ff == PH_WAIT_PRED) ? !req_data.predecessor_busy : !pend;
                     fsrc = phase_ff == PH_WAIT_PRED && sdev_ff;
                     fdst = (phase_ff == PH_WAIT_PRED && !sdev_ff && ddev_ff) ||
                            (phase_ff == PH_FLUSH_SRC && ddev_ff);
                     if (go) begin
                        priority if (phase_ff == PH_WAIT_PRED && len_ff == 64'd0) begin
                           r.action = dcs_pkg::ACT_PUBLISH;
                           r.done_token = tok_ff;
                           r.done_status = dcs_pkg::ST_OK;
                           phase_in = PH_IDLE;
                        end else if (fsrc || fdst) begin
                           if (!pend) begin
                              r.action = dcs_pkg::ACT_CACHE;
                              r.cmd_addr0 = fsrc ? csrc : cdst;
                              r.cmd_length = len_ff;
                              phase_in = fsrc ? PH_FLUSH_SRC : PH_FLUSH_DST;
                              ticks_in = '0;
                           end
                        end else if (phase_ff == PH_FLUSH_DST && sdev_ff && ddev_ff) begin
                           r.action = dcs_pkg::ACT_DEV_DMA;
                           r.cmd_addr0 = csrc; r.cmd_addr1 = cdst;
                           r.cmd_length = len_ff;
                           phase_in = PH_WAIT_DMA; ticks_in = '0;
                        end else begin
                           r.action = dcs_pkg::ACT_HOST_DMA;
                           r.cmd_addr0 = sdev_ff ? cdst : csrc;
                           r.cmd_addr1 = sdev_ff ? csrc : cdst;
                           r.cmd_length = sdev_ff ? -len_ff : len_ff;
                           phase_in = PH_WAIT_DMA; ticks_in = '0;
                        end
                     end
                  end
                  PH_WAIT_DMA: begin
                     if (s == dcs_pkg::DMA_DONE) begin
                        if (!ddev_ff) begin
                           r.action = dcs_pkg::ACT_PUBLISH;
                           r.done_token = tok_ff;
                           r.done_status = dcs_pkg::ST_OK;
                           phase_in = PH_IDLE;
                        end else if (!pend) begin
                           r.action = dcs_pkg::ACT_CACHE;
                           r.cmd_addr0 = cdst; r.cmd_length = len_ff;
                           r.cache_mode = 1'b1;
                           phase_in = PH_INV_DST; ticks_in = '0;
                        end
                     end else if (s == dcs_pkg::DMA_BUS_ERR || s == dcs_pkg::DMA_BAD_DSC) begin
                        r.action = dcs_pkg::ACT_PUBLISH;
                        r.done_token = tok_ff;
                        r.done_status = (s == dcs_pkg::DMA_BUS_ERR) ?
                                        dcs_pkg::ST_BUS_ERROR : dcs_pkg::ST_BAD_RANGE;
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_INV_DST: begin
                     if (!pend) begin
                        r.action = dcs_pkg::ACT_PUBLISH;
                        r.done_token = tok_ff;
                        r.done_status = dcs_pkg::ST_OK;
                        phase_in = PH_IDLE;
                     end
                  end
                  default: begin
                     // drain: wait until both engines are idle or report a terminal status
                     if ((hs == dcs_pkg::DMA_IDLE || (hs >= 3'd2 && hs <= 3'd4)) &&
                         (ds == dcs_pkg::DMA_IDLE || (ds >= 3'd2 && ds <= 3'd4)))
                        phase_in = PH_IDLE;
                  end
               endcase
            end
         end
         default: ;
      endcase
      r.busy_res = phase_in != PH_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ticks_ff <= '0;
         src_ff <= '0; dst_ff <= '0; len_ff <= '0; tok_ff <= '0;
         sdev_ff <= 1'b0; ddev_ff <= 1'b0;
         win_ff <= '0;
         tmo_ff <= dcs_pkg::TIMEOUT_RESET;
         out_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               dcs_pkg::CSR_GMEM_BASE: win_ff[0].base <= csr_wdata;
               dcs_pkg::CSR_GMEM_SIZE: win_ff[0].size <= csr_wdata;
               dcs_pkg::CSR_NC_BASE:   win_ff[1].base <= csr_wdata;
               dcs_pkg::CSR_NC_SIZE:   win_ff[1].size <= csr_wdata;
               dcs_pkg::CSR_HEAP_BASE: win_ff[2].base <= csr_wdata;
               dcs_pkg::CSR_HEAP_SIZE: win_ff[2].size <= csr_wdata;
               dcs_pkg::CSR_TIMEOUT:   tmo_ff <= csr_wdata[31:0];
               default: ;
            endcase
         end
         if (acc) begin
            phase_ff <= phase_in; ticks_ff <= ticks_in;
            src_ff <= src_in; dst_ff <= dst_in; len_ff <= len_in; tok_ff <= tok_in;
            sdev_ff <= sdev_in; ddev_ff <= ddev_in;
         end
         // output register plus skid stage
         if (!out_v_ff || rsp_ready) begin
            if (skid_v_ff) begin
               out_ff <= skid_ff; out_v_ff <= 1'b1; skid_v_ff <= 1'b0;
            end else begin
               out_ff <= r; out_v_ff <= acc;
            end
         end else if (acc) begin
            skid_ff <= r; skid_v_ff <= 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/dcs_window_check.sv =====
// ---------------------------------------------------------------------------
// dcs_window_check
// Checks that a device range lies inside one of three address windows.
// ---------------------------------------------------------------------------
module dcs_window_check (
   input  logic [63:0]               addr,
   input  logic [63:0]               len,
   input  dcs_pkg::window_type [2:0] win,
   output logic                      inside_ok
);

   logic [2:0] hit;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [63:0] off;
         off = addr - win[i].base;
         hit[i] = (len != 64'd0) && (addr >= win[i].base) && (off <= win[i].size)
                  && (len <= (win[i].size - off));
      end
   end

   assign inside_ok = |hit;

endmodule
